// File: sv/mbps_pkg.sv
// Shared types and constants for the masked byte pattern scanner.
package mbps_pkg;

  localparam int MAX_PATTERN_BYTES = 40;
  localparam int PAT_REG_COUNT     = 5;
  localparam int LEN_W             = 6;
  localparam int COUNT_W           = 32;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LO     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_THIRD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_FOURTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HI     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CARE_MASK      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd6;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef logic [MAX_PATTERN_BYTES-1:0][7:0] pat_bytes_t;
  typedef logic [MAX_PATTERN_BYTES-1:0]      care_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_image;
  } in_t;

  typedef struct packed {
    logic               found;
    logic [COUNT_W-1:0] match_offset;
  } out_t;

  // Pattern laid out against the window: entry j lines up with window entry j
  // (entry 0 is the newest byte). Entries beyond the pattern length never care.
  typedef struct packed {
    pat_bytes_t         pat;
    care_t              care;
    logic [LEN_W-1:0]   len_m1;
  } align_t;

endpackage

// File: sv/masked_byte_pattern_scanner.sv
// Top level of the masked byte pattern scanner.
//
// Bytes of an image arrive on the in_ channel, one per transaction, with
// end_of_image set on the final byte. The pattern, care mask and length are
// written through the cfg_ channel while no image is in flight; cfg_ready is
// always high. For each image exactly one transaction leaves on the out_
// channel: found = 1 with the start offset of the first match, or found = 0
// when the image ends without one.
// The byte is first held in the input register, and the window compare loads
// the result register from it once the result register can take a value.
// One byte is taken every cycle while the receiver does not stall; the rate is
// set by the combinational compare of all 40 window entries against the aligned
// pattern. Configuration takes effect once the written register and then the
// aligned pattern register have reloaded.
// Reset clears the byte count, the match-reported flag and both valid flags; the
// configuration returns to an all-wildcard pattern of length one. When the
// receiver stalls, the result register holds and the input register fills;
// in_ready then falls until the result is taken.
module masked_byte_pattern_scanner (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  mbps_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mbps_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [mbps_pkg::PAT_REG_COUNT-1:0][mbps_pkg::CFG_DATA_W-1:0] pat_regs_r;
  mbps_pkg::care_t                    care_r;
  logic [mbps_pkg::LEN_W-1:0]         len_r;
  mbps_pkg::pat_bytes_t               pattern;
  mbps_pkg::align_t                   align_r;

  logic                               in_v_r;
  mbps_pkg::in_t                      in_r;
  mbps_pkg::pat_bytes_t               window_r;
  mbps_pkg::pat_bytes_t               window_nxt;
  logic [mbps_pkg::COUNT_W-1:0]       seen_r;
  logic [mbps_pkg::COUNT_W-1:0]       seen_nxt;
  logic                               reported_r;
  logic                               out_v_r;
  logic                               out_v_nxt;
  mbps_pkg::out_t                     out_r;

  logic                               advance;
  logic                               all_match;
  logic                               hit;
  logic                               emit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_regs_r <= '0;
      care_r     <= '0;
      len_r      <= mbps_pkg::LEN_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mbps_pkg::CFG_PATTERN_LO:     pat_regs_r[0] <= cfg_data;
        mbps_pkg::CFG_PATTERN_SECOND: pat_regs_r[1] <= cfg_data;
        mbps_pkg::CFG_PATTERN_THIRD:  pat_regs_r[2] <= cfg_data;
        mbps_pkg::CFG_PATTERN_FOURTH: pat_regs_r[3] <= cfg_data;
        mbps_pkg::CFG_PATTERN_HI:     pat_regs_r[4] <= cfg_data;
        mbps_pkg::CFG_CARE_MASK:
          care_r <= cfg_data[mbps_pkg::MAX_PATTERN_BYTES-1:0];
        mbps_pkg::CFG_PATTERN_LENGTH: len_r <= cfg_data[mbps_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Byte k of the pattern sits at bits 8k+7..8k of the concatenated registers.
  assign pattern = mbps_pkg::pat_bytes_t'(pat_regs_r);

  mbps_align u_align (
    .clk            (clk),
    .pattern        (pattern),
    .care_mask      (care_r),
    .pattern_length (len_r),
    .align_r        (align_r)
  );

  // The input register moves on whenever the result register can take a value.
  assign advance  = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
  end

  assign window_nxt = {window_r[mbps_pkg::MAX_PATTERN_BYTES-2:0], in_r.data_byte};

  mbps_match u_match (
    .window    (window_nxt),
    .align     (align_r),
    .all_match (all_match)
  );

  // A match needs the whole pattern to lie inside the image seen so far.
  assign hit  = !reported_r && all_match &&
                (seen_r >= mbps_pkg::COUNT_W'(align_r.len_m1));
  assign emit = hit || (in_r.end_of_image && !reported_r);

  assign seen_nxt = (seen_r == mbps_pkg::COUNT_MAX) ? seen_r
                                                    : seen_r + mbps_pkg::COUNT_W'(1);

  always_ff @(posedge clk) begin
    if (advance) begin
      window_r <= window_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= '0;
      reported_r <= 1'b0;
    end else if (advance) begin
      if (in_r.end_of_image) begin
        seen_r     <= '0;
        reported_r <= 1'b0;
      end else begin
        seen_r     <= seen_nxt;
        reported_r <= reported_r || hit;
      end
    end
  end

  always_comb begin
    if (advance && emit) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_r.found        <= hit;
      out_r.match_offset <= hit ? (seen_r - mbps_pkg::COUNT_W'(align_r.len_m1)) : '0;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// File: sv/mbps_align.sv
// Reorders the configured pattern so it lines up with the byte window.
module mbps_align (
  input  logic                       clk,
  input  mbps_pkg::pat_bytes_t       pattern,
  input  mbps_pkg::care_t            care_mask,
  input  logic [mbps_pkg::LEN_W-1:0] pattern_length,
  output mbps_pkg::align_t           align_r
);

  mbps_pkg::align_t          align_nxt;
  logic [mbps_pkg::LEN_W-1:0] len_m1;

  // Length zero acts as one, lengths past the window act as the full window.
  always_comb begin
    if (pattern_length == '0) begin
      len_m1 = '0;
    end else if (pattern_length > mbps_pkg::LEN_W'(mbps_pkg::MAX_PATTERN_BYTES)) begin
      len_m1 = mbps_pkg::LEN_W'(mbps_pkg::MAX_PATTERN_BYTES - 1);
    end else begin
      len_m1 = pattern_length - mbps_pkg::LEN_W'(1);
    end
  end

  always_comb begin
    logic [mbps_pkg::LEN_W-1:0] k;
    align_nxt.len_m1 = len_m1;
    for (int j = 0; j < mbps_pkg::MAX_PATTERN_BYTES; j++) begin
      k = len_m1 - mbps_pkg::LEN_W'(j);
      if (mbps_pkg::LEN_W'(j) <= len_m1) begin
        align_nxt.pat[j]  = pattern[k];
        align_nxt.care[j] = care_mask[k];
      end else begin
        align_nxt.pat[j]  = '0;
        align_nxt.care[j] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    align_r <= align_nxt;
  end

endmodule

// File: sv/mbps_match.sv
// Compares the shifted byte window against the aligned pattern in one pass.
module mbps_match (
  input  mbps_pkg::pat_bytes_t window,
  input  mbps_pkg::align_t     align,
  output logic                 all_match
);

  mbps_pkg::care_t byte_ok;

  always_comb begin
    for (int j = 0; j < mbps_pkg::MAX_PATTERN_BYTES; j++) begin
      byte_ok[j] = !align.care[j] || (window[j] == align.pat[j]);
    end
  end

  assign all_match = &byte_ok;

endmodule

// File: sv/mbps_checker.sv
// Port-level checks for the masked byte pattern scanner, bound to the top level.
module mbps_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input mbps_pkg::out_t                  out_data
);

  // A stalled result must hold until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A not-found result always carries a zero offset.
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.match_offset == '0)
    else $error("not-found result with nonzero offset");

  // Nothing leaves the block in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // With no input handshake in the antecedent and the output drained, nothing new appears.
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready) ##1 !(in_valid && in_ready) && !out_valid
      |=> !out_valid)
    else $error("result without a pending transaction");

endmodule

bind masked_byte_pattern_scanner mbps_checker u_mbps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
